### hdl/erp_pkg.sv
// Shared types, constants and helper functions for the rotate-and-project block.
package erp_pkg;

    localparam int CORDIC_W   = 34;
    localparam int ATAN_COUNT = 24;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam int TRIG_W    = 16;
    localparam int CF_W      = TRIG_W + 1;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int QUOT_BITS = TRIG_W + 1;
    localparam int DIV_LAT   = QUOT_BITS + 2;

    localparam logic signed [TRIG_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [TRIG_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] REG_PUSH_DEPTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd4;

    localparam logic [CFG_W-1:0] RST_PUSH_DEPTH      = 10'd200;
    localparam logic [CFG_W-1:0] RST_FOCAL_LENGTH    = 10'd256;
    localparam logic [CFG_W-1:0] RST_CAMERA_DISTANCE = 10'd100;
    localparam logic [CFG_W-1:0] RST_CENTER_X        = 10'd240;
    localparam logic [CFG_W-1:0] RST_CENTER_Y        = 10'd136;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       neg;
    } cordic_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } sincos_t;

    typedef struct packed {
        logic [CFG_W-1:0] push_depth;
        logic [CFG_W-1:0] focal_length;
        logic [CFG_W-1:0] camera_distance;
        logic [CFG_W-1:0] center_x;
        logic [CFG_W-1:0] center_y;
    } cfg_t;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    function automatic logic [31:0] atan_phase(input int unsigned i);
        case (i)
            0:       return 32'd536870912;
            1:       return 32'd316933406;
            2:       return 32'd167458907;
            3:       return 32'd85004756;
            4:       return 32'd42667331;
            5:       return 32'd21354465;
            6:       return 32'd10679838;
            7:       return 32'd5340245;
            8:       return 32'd2670163;
            9:       return 32'd1335087;
            10:      return 32'd667544;
            11:      return 32'd333772;
            12:      return 32'd166886;
            13:      return 32'd83443;
            14:      return 32'd41722;
            15:      return 32'd20861;
            16:      return 32'd10430;
            17:      return 32'd5215;
            18:      return 32'd2608;
            19:      return 32'd1304;
            20:      return 32'd652;
            21:      return 32'd326;
            22:      return 32'd163;
            23:      return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    // Q4.30 -> Q1.15 with round half up and saturation
    function automatic logic signed [TRIG_W-1:0] round_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0]    sum;
        logic signed [CORDIC_W-15:0] t;
        sum = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(16384);
        t   = sum[CORDIC_W:15];
        if (t > 32767)
            return SAT_MAX;
        else if (t < -32768)
            return SAT_MIN;
        else
            return t[TRIG_W-1:0];
    endfunction

endpackage

### hdl/erp_queue.sv
// Small register-based FIFO used between pipeline sections.
module erp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = cnt_reg != (AW+1)'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        rd_next  = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_next;
            if (do_pop)
                rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

### hdl/erp_front.sv
// Front section: takes vertices and runs three pipelined CORDIC sine/cosine units.
module erp_front #(
    parameter int COORD_BITS   = 12,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  vert_x,
    input  logic signed [COORD_BITS-1:0]  vert_y,
    input  logic signed [COORD_BITS-1:0]  vert_z,
    input  logic [ANGLE_BITS-1:0]         rot_x,
    input  logic [ANGLE_BITS-1:0]         rot_y,
    input  logic [ANGLE_BITS-1:0]         rot_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  out_x,
    output logic signed [COORD_BITS-1:0]  out_y,
    output logic signed [COORD_BITS-1:0]  out_z,
    output erp_pkg::sincos_t [2:0]        out_trig
);
    import erp_pkg::*;

    localparam int NS  = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int LAT = NS + 2;

    logic [LAT-1:0]               vld_reg;
    logic                         adv;
    cordic_t                      st_reg [NS+1][3];
    cordic_t                      st0_next [3];
    logic signed [COORD_BITS-1:0] vx_reg [LAT];
    logic signed [COORD_BITS-1:0] vy_reg [LAT];
    logic signed [COORD_BITS-1:0] vz_reg [LAT];
    sincos_t [2:0]                trig_reg;
    logic [ANGLE_BITS-1:0]        ang [3];

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];
    assign out_x     = vx_reg[LAT-1];
    assign out_y     = vy_reg[LAT-1];
    assign out_z     = vz_reg[LAT-1];
    assign out_trig  = trig_reg;

    assign ang[0] = rot_x;
    assign ang[1] = rot_y;
    assign ang[2] = rot_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0] <= vert_x;
            vy_reg[0] <= vert_y;
            vz_reg[0] <= vert_z;
            for (int k = 1; k < LAT; k++)
            begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    // fold the middle half turn onto the right half plane, negate at the end
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic [31:0] ph;
            logic        neg;
            ph  = {ang[a], {(32-ANGLE_BITS){1'b0}}};
            neg = ph[31] ^ ph[30];
            st0_next[a].x   = CORDIC_X0;
            st0_next[a].y   = '0;
            st0_next[a].z   = CORDIC_W'($signed({ph[31] ^ neg, ph[30:0]}));
            st0_next[a].neg = neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int a = 0; a < 3; a++)
                st_reg[0][a] <= st0_next[a];
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_iter
        cordic_t nxt [3];

        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                nxt[a] = st_reg[k-1][a];
                if (!st_reg[k-1][a].z[CORDIC_W-1])
                begin
                    nxt[a].x = $signed(st_reg[k-1][a].x) - ($signed(st_reg[k-1][a].y) >>> (k-1));
                    nxt[a].y = $signed(st_reg[k-1][a].y) + ($signed(st_reg[k-1][a].x) >>> (k-1));
                    nxt[a].z = $signed(st_reg[k-1][a].z)
                               - $signed({2'b00, atan_phase(k-1)});
                end
                else
                begin
                    nxt[a].x = $signed(st_reg[k-1][a].x) + ($signed(st_reg[k-1][a].y) >>> (k-1));
                    nxt[a].y = $signed(st_reg[k-1][a].y) - ($signed(st_reg[k-1][a].x) >>> (k-1));
                    nxt[a].z = $signed(st_reg[k-1][a].z)
                               + $signed({2'b00, atan_phase(k-1)});
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                for (int a = 0; a < 3; a++)
                    st_reg[k][a] <= nxt[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int a = 0; a < 3; a++)
            begin
                trig_reg[a].c <= round_q15(st_reg[NS][a].neg ? -st_reg[NS][a].x : st_reg[NS][a].x);
                trig_reg[a].s <= round_q15(st_reg[NS][a].neg ? -st_reg[NS][a].y : st_reg[NS][a].y);
            end
    end

endmodule

### hdl/erp_div.sv
// Pipelined restoring divider, truncating toward zero, saturated 16-bit quotient.
module erp_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 24
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [NUM_W-1:0]           num,
    input  logic signed [DEN_W-1:0]           den,
    output logic signed [erp_pkg::TRIG_W-1:0] quot
);
    import erp_pkg::*;

    localparam int RW = (NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS;

    logic [RW-1:0]        r_reg [QUOT_BITS+1];
    logic [RW-1:0]        d_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] q_reg [QUOT_BITS+1];
    logic                 neg_reg [QUOT_BITS+1];
    logic                 ovf_reg [QUOT_BITS+1];
    logic signed [TRIG_W-1:0] quot_reg;
    logic [NUM_W-1:0]     mag;

    assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign quot = quot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= RW'(mag);
            d_reg[0]   <= RW'($unsigned(den));
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar k = 1; k <= QUOT_BITS; k++)
    begin : g_step
        logic [RW-1:0] trial;
        assign trial = d_reg[k-1] << (QUOT_BITS-k);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                if (r_reg[k-1] >= trial)
                begin
                    r_reg[k] <= r_reg[k-1] - trial;
                    q_reg[k] <= q_reg[k-1] | (QUOT_BITS'(1) << (QUOT_BITS-k));
                end
                else
                begin
                    r_reg[k] <= r_reg[k-1];
                    q_reg[k] <= q_reg[k-1];
                end
                // quotient too wide for the 17-bit result: saturate
                if (k == 1)
                    ovf_reg[k] <= r_reg[0] >= (d_reg[0] << QUOT_BITS);
                else
                    ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[QUOT_BITS])
                quot_reg <= neg_reg[QUOT_BITS] ? SAT_MIN : SAT_MAX;
            else if (neg_reg[QUOT_BITS])
                quot_reg <= (q_reg[QUOT_BITS] > QUOT_BITS'(2**(TRIG_W-1)))
                            ? SAT_MIN : TRIG_W'(-q_reg[QUOT_BITS]);
            else
                quot_reg <= (q_reg[QUOT_BITS] > QUOT_BITS'(2**(TRIG_W-1) - 1))
                            ? SAT_MAX : $signed(q_reg[QUOT_BITS][TRIG_W-1:0]);
        end
    end

endmodule

### hdl/erp_back.sv
// Back section: three rotations, depth offset, perspective divide and center select.
module erp_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  erp_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_BITS-1:0]      in_x,
    input  logic signed [COORD_BITS-1:0]      in_y,
    input  logic signed [COORD_BITS-1:0]      in_z,
    input  erp_pkg::sincos_t [2:0]            in_trig,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [erp_pkg::TRIG_W-1:0] out_sx,
    output logic signed [erp_pkg::TRIG_W-1:0] out_sy,
    output logic                              out_behind
);
    import erp_pkg::*;

    localparam int CW  = COORD_BITS + 12;
    localparam int PW  = CW + CF_W;
    localparam int SW  = PW + 1;
    localparam int NW  = CW + CFG_W + 2;
    localparam int LAT = 9 + DIV_LAT;

    logic [LAT-1:0] vld_reg;
    logic           adv;

    logic signed [PW-1:0] pa_reg [4];
    logic signed [PW-1:0] pb_reg [4];
    logic signed [PW-1:0] pc_reg [4];
    logic signed [CW-1:0] x1_reg, x2_reg, y2_reg, z2_reg, y3_reg;
    logic signed [CW-1:0] x4_reg, y4_reg, z4_reg, z5_reg;
    logic signed [CW-1:0] x6_reg, y6_reg, z6_reg;
    logic signed [CW-1:0] x7_reg, y7_reg, den7_reg, den8_reg, den9_reg;
    logic signed [CW-1:0] den_next;
    logic                 beh7_reg, beh8_reg, beh9_reg;
    logic                 beh_reg [DIV_LAT];
    logic signed [NW-1:0] fx_reg, cx_reg, fy_reg, cy_reg, numx_reg, numy_reg;
    sincos_t [2:0]        tr1_reg, tr2_reg, tr3_reg, tr4_reg;
    logic [CFG_W:0]       off;
    logic signed [TRIG_W-1:0] qx, qy;

    function automatic logic signed [PW-1:0] mul(input logic signed [CW-1:0] a,
                                                 input logic signed [CF_W-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic logic signed [CF_W-1:0] pos(input logic signed [TRIG_W-1:0] v);
        return CF_W'(v);
    endfunction

    function automatic logic signed [CF_W-1:0] ngt(input logic signed [TRIG_W-1:0] v);
        return -CF_W'(v);
    endfunction

    function automatic logic signed [CW-1:0] mix(input logic signed [PW-1:0] p,
                                                 input logic signed [PW-1:0] q);
        logic signed [SW-1:0] sum;
        sum = SW'(p) + SW'(q) + SW'(16384);
        return sum[CW+14:15];
    endfunction

    function automatic logic signed [NW-1:0] mulf(input logic signed [CW-1:0] a,
                                                  input logic [CFG_W-1:0] f);
        return NW'(a) * NW'($signed({1'b0, f}));
    endfunction

    assign adv        = !vld_reg[LAT-1] || out_ready;
    assign in_ready   = adv;
    assign out_valid  = vld_reg[LAT-1];
    assign out_behind = beh_reg[DIV_LAT-1];
    assign out_sx     = beh_reg[DIV_LAT-1] ? TRIG_W'(cfg.center_x) : qx;
    assign out_sy     = beh_reg[DIV_LAT-1] ? TRIG_W'(cfg.center_y) : qy;

    assign off      = {1'b0, cfg.push_depth} + {1'b0, cfg.camera_distance};
    assign den_next = z6_reg + CW'($signed({1'b0, off, 8'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // rotation about X
            x1_reg    <= CW'($signed({in_x, 8'b0}));
            pa_reg[0] <= mul(CW'($signed({in_y, 8'b0})), pos(in_trig[0].c));
            pa_reg[1] <= mul(CW'($signed({in_z, 8'b0})), ngt(in_trig[0].s));
            pa_reg[2] <= mul(CW'($signed({in_y, 8'b0})), pos(in_trig[0].s));
            pa_reg[3] <= mul(CW'($signed({in_z, 8'b0})), pos(in_trig[0].c));
            tr1_reg   <= in_trig;

            x2_reg  <= x1_reg;
            y2_reg  <= mix(pa_reg[0], pa_reg[1]);
            z2_reg  <= mix(pa_reg[2], pa_reg[3]);
            tr2_reg <= tr1_reg;

            // rotation about Y
            y3_reg    <= y2_reg;
            pb_reg[0] <= mul(x2_reg, pos(tr2_reg[1].c));
            pb_reg[1] <= mul(z2_reg, pos(tr2_reg[1].s));
            pb_reg[2] <= mul(x2_reg, ngt(tr2_reg[1].s));
            pb_reg[3] <= mul(z2_reg, pos(tr2_reg[1].c));
            tr3_reg   <= tr2_reg;

            y4_reg  <= y3_reg;
            x4_reg  <= mix(pb_reg[0], pb_reg[1]);
            z4_reg  <= mix(pb_reg[2], pb_reg[3]);
            tr4_reg <= tr3_reg;

            // rotation about Z
            z5_reg    <= z4_reg;
            pc_reg[0] <= mul(x4_reg, pos(tr4_reg[2].c));
            pc_reg[1] <= mul(y4_reg, ngt(tr4_reg[2].s));
            pc_reg[2] <= mul(x4_reg, pos(tr4_reg[2].s));
            pc_reg[3] <= mul(y4_reg, pos(tr4_reg[2].c));

            z6_reg <= z5_reg;
            x6_reg <= mix(pc_reg[0], pc_reg[1]);
            y6_reg <= mix(pc_reg[2], pc_reg[3]);

            // perspective denominator, Q.8
            x7_reg   <= x6_reg;
            y7_reg   <= y6_reg;
            den7_reg <= den_next;
            beh7_reg <= den_next[CW-1] || (den_next == '0);

            fx_reg   <= mulf(x7_reg, cfg.focal_length);
            cx_reg   <= mulf(den7_reg, cfg.center_x);
            fy_reg   <= mulf(y7_reg, cfg.focal_length);
            cy_reg   <= mulf(den7_reg, cfg.center_y);
            den8_reg <= den7_reg;
            beh8_reg <= beh7_reg;

            numx_reg <= fx_reg + cx_reg;
            numy_reg <= fy_reg + cy_reg;
            den9_reg <= den8_reg;
            beh9_reg <= beh8_reg;

            beh_reg[0] <= beh9_reg;
            for (int k = 1; k < DIV_LAT; k++)
                beh_reg[k] <= beh_reg[k-1];
        end
    end

    erp_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div_x (
        .clk  (clk),
        .en   (adv),
        .num  (numx_reg),
        .den  (den9_reg),
        .quot (qx)
    );

    erp_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div_y (
        .clk  (clk),
        .en   (adv),
        .num  (numy_reg),
        .den  (den9_reg),
        .quot (qy)
    );

endmodule

### hdl/euler_rotate_perspective_project.sv
// CORDIC stages, rotation multipliers and divider are pipelined.
// Throughput: one vertex per cycle while full is low (no back-pressure from the queues).
// Front (CORDIC) and back (rotate/project) stall independently through a 4-entry queue.
// Reset: rst_n asynchronous, active low; clears pipeline valids and queues, loads register
// defaults (push 200, focal 256, distance 100, center 240/136). No clearing pass.
// Top level: vertex rotate and perspective project stage.
module euler_rotate_perspective_project #(
    parameter int COORD_BITS   = 12,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [COORD_BITS-1:0]         vert_x,
    input  logic signed [COORD_BITS-1:0]         vert_y,
    input  logic signed [COORD_BITS-1:0]         vert_z,
    input  logic [ANGLE_BITS-1:0]                rot_x,
    input  logic [ANGLE_BITS-1:0]                rot_y,
    input  logic [ANGLE_BITS-1:0]                rot_z,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [erp_pkg::TRIG_W-1:0]    screen_x,
    output logic signed [erp_pkg::TRIG_W-1:0]    screen_y,
    output logic                                 behind_camera,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [erp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [erp_pkg::CFG_W-1:0]            cfg_data
);
    import erp_pkg::*;

    localparam int MID_W = 3*COORD_BITS + 3*2*TRIG_W;
    localparam int OUT_W = 2*TRIG_W + 1;

    cfg_t cfg_reg;

    logic                         front_ready, front_valid, mid_ready;
    logic signed [COORD_BITS-1:0] fx, fy, fz, bx, by, bz;
    sincos_t [2:0]                ftrig, btrig;
    logic                         mid_valid, back_ready;
    logic                         back_valid, outq_ready;
    logic signed [TRIG_W-1:0]     back_sx, back_sy;
    logic                         back_behind;
    logic                         outq_valid;

    assign cfg_ready = 1'b1;
    assign full      = !front_ready;
    assign empty     = !outq_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_depth      <= RST_PUSH_DEPTH;
            cfg_reg.focal_length    <= RST_FOCAL_LENGTH;
            cfg_reg.camera_distance <= RST_CAMERA_DISTANCE;
            cfg_reg.center_x        <= RST_CENTER_X;
            cfg_reg.center_y        <= RST_CENTER_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PUSH_DEPTH:      cfg_reg.push_depth      <= cfg_data;
                REG_FOCAL_LENGTH:    cfg_reg.focal_length    <= cfg_data;
                REG_CAMERA_DISTANCE: cfg_reg.camera_distance <= cfg_data;
                REG_CENTER_X:        cfg_reg.center_x        <= cfg_data;
                REG_CENTER_Y:        cfg_reg.center_y        <= cfg_data;
                default:             ;
            endcase
        end
    end

    erp_front #(
        .COORD_BITS   (COORD_BITS),
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (front_ready),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .vert_z    (vert_z),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .out_valid (front_valid),
        .out_ready (mid_ready),
        .out_x     (fx),
        .out_y     (fy),
        .out_z     (fz),
        .out_trig  (ftrig)
    );

    erp_queue #(
        .WIDTH (MID_W),
        .DEPTH (4)
    ) u_mid_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (mid_ready),
        .push_data  ({fx, fy, fz, ftrig}),
        .pop_valid  (mid_valid),
        .pop_ready  (back_ready),
        .pop_data   ({bx, by, bz, btrig})
    );

    erp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (mid_valid),
        .in_ready   (back_ready),
        .in_x       (bx),
        .in_y       (by),
        .in_z       (bz),
        .in_trig    (btrig),
        .out_valid  (back_valid),
        .out_ready  (outq_ready),
        .out_sx     (back_sx),
        .out_sy     (back_sy),
        .out_behind (back_behind)
    );

    erp_queue #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (back_valid),
        .push_ready (outq_ready),
        .push_data  ({back_sx, back_sy, back_behind}),
        .pop_valid  (outq_valid),
        .pop_ready  (pop),
        .pop_data   ({screen_x, screen_y, behind_camera})
    );

`ifndef SYNTHESIS
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !mid_ready |=> front_valid)
        else $error("front result dropped while queue full");

    a_back_hold: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && !outq_ready |=> back_valid)
        else $error("back result dropped while output queue full");

    a_behind_center: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && back_behind |-> !back_sx[TRIG_W-1] && !back_sy[TRIG_W-1])
        else $error("behind-camera result not on the center");
`endif

endmodule
